// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker spk_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("assertion failed in same-cycle check");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("assertion failed in next-cycle check");

`endif

// ----- rtl/spk_pkg.sv -----
`timescale 1ns / 1ps
package spk_pkg;

  // Tone generator constants.
  localparam int unsigned LOOP_CAPACITY  = 1792;
  localparam int unsigned SAMPLE_RATE_HZ = 32000;
  localparam int unsigned TIMER_CLOCK_HZ = 1193182;
  localparam int unsigned MAX_TONE_HZ    = SAMPLE_RATE_HZ / 2;
  localparam int unsigned MIN_COUNT      = (TIMER_CLOCK_HZ + MAX_TONE_HZ - 1) / MAX_TONE_HZ;

  // Field widths.
  localparam int unsigned COUNT_W = 17;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned PHASE_W = 32;

  // Divider operand widths: the phase step numerator is the timer clock shifted by 32.
  localparam int unsigned DVD_W = 53;
  localparam int unsigned DSR_W = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam logic [DVD_W-1:0] PHASE_NUM = DVD_W'(64'(TIMER_CLOCK_HZ) << 32);
  localparam logic [DVD_W-1:0] LOOP_NUM  =
    DVD_W'(64'(LOOP_CAPACITY) * 64'(TIMER_CLOCK_HZ));
  localparam logic [DSR_W-1:0] HALF_CLK  = DSR_W'(TIMER_CLOCK_HZ >> 1);

  // Commands.
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;

  // Result kinds.
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_SAMPLE = 2'd2;

  // Timer mode that plays (square wave).
  localparam logic [2:0] MODE_SQUARE = 3'd3;

  // Sample levels.
  localparam logic [7:0] SMP_LOW     = 8'd32;
  localparam logic [7:0] SMP_HIGH    = 8'd224;
  localparam logic [7:0] SMP_SILENCE = 8'd128;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/pc_speaker_square_wave_port.sv -----
`timescale 1ns / 1ps
// Speaker control port with a square-wave audio source.
// Input channel (in_valid/in_ready) carries one request: a port read, a port
// write or one audio sample request. Output channel (out_valid/out_ready)
// carries at most one result per request; unused commands, sample requests in
// a timer mode other than square wave, and sample requests while audio is off
// give no result.
// One request is processed at a time; in_ready is high only when the block is
// idle, so a new request is taken only once the last one has left the done
// state. Reads and writes pass from idle through the execute and done states;
// samples at an unchanged count, or at a new count below the playable range,
// pass through execute, play and done. A sample request whose timer count
// changed to a playable value runs the shared restoring divider three times
// (phase step, loop length numerator, loop length), each through a start and
// a wait state, before play and done.
// A finished result sits in the output register; the block takes the next
// request while it waits. If the receiver stalls, the following result holds
// inside the block until the output register frees up.
// Reset empties the output register and starts a silent loop of 1792 samples
// with the gate and data enable cleared.
module pc_speaker_square_wave_port (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [7:0]                  write_value,
  input  logic                        timer_gate_in,
  input  logic                        timer_out_in,
  input  logic [2:0]                  timer_mode,
  input  logic [spk_pkg::COUNT_W-1:0] timer_initial_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  result_kind,
  output logic [5:0]                  read_data,
  output logic                        gate_to_timer,
  output logic                        audio_active,
  output logic [7:0]                  sample
);
  import spk_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_DIV_GO   = 3'd2;
  localparam logic [2:0] S_DIV_WAIT = 3'd3;
  localparam logic [2:0] S_PLAY     = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  localparam logic [1:0] SEL_PHASE = 2'd0;
  localparam logic [1:0] SEL_WHOLE = 2'd1;
  localparam logic [1:0] SEL_LEN   = 2'd2;

  logic [2:0]         state;
  logic [1:0]         div_sel;

  // Latched request.
  logic [1:0]         req_cmd;
  logic [7:0]         req_wval;
  logic               req_gate;
  logic               req_tout;
  logic [2:0]         req_mode;
  logic [COUNT_W-1:0] req_count;

  // Tone state.
  logic [COUNT_W-1:0] last_count;
  logic [PHASE_W-1:0] phase_step;
  logic [PHASE_W-1:0] phase_acc;
  logic [POS_W-1:0]   loop_length;
  logic [POS_W-1:0]   play_position;
  logic               data_enable;
  logic               gate_level;
  logic               refresh_toggle;

  // Pending result.
  logic [1:0]         res_kind;
  logic [5:0]         res_read;
  logic               res_gate;
  logic               res_active;
  logic [7:0]         res_sample;

  logic [DSR_W-1:0]   divisor_m;
  logic [DSR_W-1:0]   whole;

  logic [COUNT_W-1:0] eff_count;
  logic               refresh_next;
  logic [POS_W:0]     pos_inc;
  logic [DSR_W:0]     len_sum;
  logic [POS_W-1:0]   len_raw;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [DVD_W-1:0]   div_dividend;
  logic [DSR_W-1:0]   div_divisor;
  logic [DSR_W-1:0]   div_quo;
  logic [DSR_W-1:0]   div_rem;

  assign in_ready = (state == S_IDLE);

  // Counts too low to play become silence.
  assign eff_count    = (req_count < COUNT_W'(MIN_COUNT)) ? '0 : req_count;
  assign refresh_next = ~refresh_toggle;
  assign pos_inc      = {1'b0, play_position} + 1'b1;
  assign len_sum      = {1'b0, div_quo} + 1'b1;
  assign len_raw      = len_sum[POS_W:1];

  // Operand selection for the shared divider.
  always_comb begin
    div_ctrl.start = (state == S_DIV_GO);
    unique case (div_sel)
      SEL_PHASE: begin
        div_dividend = PHASE_NUM;
        div_divisor  = divisor_m;
      end
      SEL_WHOLE: begin
        div_dividend = LOOP_NUM;
        div_divisor  = divisor_m;
      end
      default: begin
        div_dividend = DVD_W'(whole);
        div_divisor  = HALF_CLK;
      end
    endcase
  end

  spk_div u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Sequencer and tone state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      div_sel        <= SEL_PHASE;
      out_valid      <= 1'b0;
      last_count     <= '0;
      phase_step     <= '0;
      phase_acc      <= '0;
      loop_length    <= POS_W'(LOOP_CAPACITY);
      play_position  <= '0;
      data_enable    <= 1'b0;
      gate_level     <= 1'b0;
      refresh_toggle <= 1'b0;
    end else begin
      // The output register loads a finished result and clears once taken.
      if ((state == S_DONE) && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (req_cmd)
            CMD_READ: begin
              refresh_toggle <= refresh_next;
              state          <= S_DONE;
            end
            CMD_WRITE: begin
              gate_level  <= req_wval[0];
              data_enable <= req_wval[1];
              if (req_wval[0]) begin
                play_position <= '0;
                phase_acc     <= '0;
              end
              state <= S_DONE;
            end
            CMD_SAMPLE: begin
              if (!(gate_level && data_enable) || (req_mode != MODE_SQUARE)) begin
                state <= S_IDLE;
              end else if (eff_count != last_count) begin
                last_count    <= eff_count;
                play_position <= '0;
                phase_acc     <= '0;
                if (eff_count == '0) begin
                  phase_step  <= '0;
                  loop_length <= POS_W'(LOOP_CAPACITY);
                  state       <= S_PLAY;
                end else begin
                  div_sel <= SEL_PHASE;
                  state   <= S_DIV_GO;
                end
              end else begin
                state <= S_PLAY;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_DIV_GO: begin
          state <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_stat.done) begin
            unique case (div_sel)
              SEL_PHASE: begin
                phase_step <= div_quo;
                div_sel    <= SEL_WHOLE;
                state      <= S_DIV_GO;
              end
              SEL_WHOLE: begin
                div_sel <= SEL_LEN;
                state   <= S_DIV_GO;
              end
              default: begin
                loop_length <= (len_raw == '0) ? POS_W'(1) : len_raw;
                state       <= S_PLAY;
              end
            endcase
          end
        end
        S_PLAY: begin
          // The accumulator tracks phase_step times play_position, modulo 2^32.
          if (pos_inc >= {1'b0, loop_length}) begin
            play_position <= '0;
            phase_acc     <= '0;
          end else begin
            play_position <= pos_inc[POS_W-1:0];
            phase_acc     <= phase_acc + phase_step;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request capture, divider operands and result payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd   <= command;
      req_wval  <= write_value;
      req_gate  <= timer_gate_in;
      req_tout  <= timer_out_in;
      req_mode  <= timer_mode;
      req_count <= timer_initial_count;
    end
    if (state == S_EXEC) begin
      divisor_m  <= DSR_W'(32'(eff_count) * 32'(SAMPLE_RATE_HZ));
      res_read   <= (req_cmd == CMD_READ) ?
                    {req_tout, refresh_next, 2'b00, data_enable, req_gate} : '0;
      res_gate   <= (req_cmd == CMD_WRITE) && req_wval[0];
      res_active <= (req_cmd == CMD_WRITE) && req_wval[0] && req_wval[1];
      res_sample <= '0;
      if (req_cmd == CMD_READ) begin
        res_kind <= KIND_READ;
      end else if (req_cmd == CMD_WRITE) begin
        res_kind <= KIND_WRITE;
      end else begin
        res_kind <= KIND_SAMPLE;
      end
    end
    // Whole loop span is the numerator minus its remainder modulo m.
    if ((state == S_DIV_WAIT) && div_stat.done && (div_sel == SEL_WHOLE)) begin
      whole <= DSR_W'(LOOP_NUM) - div_rem;
    end
    if (state == S_PLAY) begin
      if (last_count == '0) begin
        res_sample <= SMP_SILENCE;
      end else begin
        res_sample <= phase_acc[PHASE_W-1] ? SMP_LOW : SMP_HIGH;
      end
    end
    if ((state == S_DONE) && (!out_valid || out_ready)) begin
      result_kind   <= res_kind;
      read_data     <= res_read;
      gate_to_timer <= res_gate;
      audio_active  <= res_active;
      sample        <= res_sample;
    end
  end

endmodule

// ----- rtl/spk_div.sv -----
`timescale 1ns / 1ps
module spk_div (
  input  logic                      clk,
  input  logic                      rst,
  input  spk_pkg::div_ctrl_t        ctrl,
  input  logic [spk_pkg::DVD_W-1:0] dividend,
  input  logic [spk_pkg::DSR_W-1:0] divisor,
  output spk_pkg::div_stat_t        stat,
  output logic [spk_pkg::DSR_W-1:0] quotient,
  output logic [spk_pkg::DSR_W-1:0] remainder
);
  import spk_pkg::*;

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVD_W-1:0]     dvd;
  logic [DSR_W-1:0]     dsr;
  logic [DSR_W-1:0]     rem;
  logic [DSR_W-1:0]     quo;
  logic [DSR_W:0]       shifted;
  logic                 fits;

  // One restoring step: bring down the next dividend bit and try to subtract.
  assign shifted = {rem, dvd[DVD_W-1]};
  assign fits    = shifted >= {1'b0, dsr};

  // Control: run one step per cycle, flag completion in the cycle after the last step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DVD_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath: quotient keeps only its low bits, which is all the caller needs.
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quo <= '0;
    end else if (busy) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      quo <= {quo[DSR_W-2:0], fits};
      if (fits) begin
        rem <= DSR_W'(shifted - {1'b0, dsr});
      end else begin
        rem <= shifted[DSR_W-1:0];
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ----- rtl/spk_chk.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module spk_chk (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [1:0]                  command,
  input logic [7:0]                  write_value,
  input logic                        timer_gate_in,
  input logic                        timer_out_in,
  input logic [2:0]                  timer_mode,
  input logic [spk_pkg::COUNT_W-1:0] timer_initial_count,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  result_kind,
  input logic [5:0]                  read_data,
  input logic                        gate_to_timer,
  input logic                        audio_active,
  input logic [7:0]                  sample
);
  import spk_pkg::*;

  logic read_shown;
  logic write_shown;
  logic sample_shown;
  logic read_clean;
  logic write_clean;
  logic sample_clean;
  logic kind_known;

  assign read_shown   = out_valid && (result_kind == KIND_READ);
  assign write_shown  = out_valid && (result_kind == KIND_WRITE);
  assign sample_shown = out_valid && (result_kind == KIND_SAMPLE);

  assign read_clean   = !gate_to_timer && !audio_active && (sample == 8'd0) &&
                        (read_data[3:2] == 2'b00);
  assign write_clean  = (!audio_active || gate_to_timer) && (read_data == 6'd0) &&
                        (sample == 8'd0);
  assign sample_clean = ((sample == SMP_LOW) || (sample == SMP_HIGH) ||
                         (sample == SMP_SILENCE)) &&
                        (read_data == 6'd0) && !gate_to_timer && !audio_active;
  assign kind_known   = (result_kind == KIND_READ) || (result_kind == KIND_WRITE) ||
                        (result_kind == KIND_SAMPLE);

  // A stalled result stays offered.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // Read results carry only read data.
  `ASSERT_SAME(a_read_clean, clk, rst, read_shown, read_clean)

  // Write acknowledgements: audio is active only with the gate set; no read data or sample.
  `ASSERT_SAME(a_write_clean, clk, rst, write_shown, write_clean)

  // Samples take only the three audio levels.
  `ASSERT_SAME(a_sample_level, clk, rst, sample_shown, sample_clean)

  // No result of an unused kind is ever shown.
  `ASSERT_SAME(a_kind_valid, clk, rst, out_valid, kind_known)

endmodule

bind pc_speaker_square_wave_port spk_chk u_spk_chk (.*);
